// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lzs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_pkg
// Shared types and constants of the layer z-order stack.
// ----------------------------------------------------------------------------
package lzs_pkg;

    // position math width; covers -1..256, enough for pools of up to 256 layers
    localparam int POS_W = 10;
    // widest layer index
    localparam int LYR_W = 8;

    localparam logic signed [POS_W-1:0] P_ONE  = 1;
    localparam logic signed [POS_W-1:0] P_NEG1 = -1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // broadcast to every position cell during the shift cycle
    typedef struct packed {
        logic                    en;
        logic                    from_left;
        logic                    ins;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] pos;
        logic [LYR_W-1:0]        layer;
    } shift_ctrl_t;

endpackage

// ===== sv/lzs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_in_if
// Command channel: one word per stacking command.
// ----------------------------------------------------------------------------
interface lzs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [3:0]        layer_id;
    logic signed [4:0] requested_height;

    modport source (
        output valid,
        output opcode,
        output layer_id,
        output requested_height,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  layer_id,
        input  requested_height,
        output ready
    );
endinterface

// ===== sv/lzs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_out_if
// Response channel: one word per command.
// ----------------------------------------------------------------------------
interface lzs_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        result_layer;
    logic              status;
    logic signed [4:0] applied_height;
    logic signed [4:0] top_height;

    modport source (
        output valid,
        output result_layer,
        output status,
        output applied_height,
        output top_height,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_layer,
        input  status,
        input  applied_height,
        input  top_height,
        output ready
    );
endinterface

// ===== sv/lzs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_cell
// One stacking position: holds the layer at that position and, on a shift,
// takes its left or right neighbor's entry or the moved layer.
// ----------------------------------------------------------------------------
module lzs_cell
    import lzs_pkg::*;
#(
    parameter int IW  = 4,
    parameter int POS = 0
)
(
    input  logic          clk,
    input  logic [IW-1:0] left,
    input  logic [IW-1:0] right,
    input  shift_ctrl_t   ctrl,
    output logic [IW-1:0] entry
);

    localparam logic signed [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [IW-1:0] entry_reg;
    logic [IW-1:0] entry_next;
    logic          in_range;

    assign in_range = (MY_POS >= ctrl.lo) && (MY_POS <= ctrl.hi);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.en)
        begin
            if (ctrl.ins && (MY_POS == ctrl.pos))
            begin
                entry_next = ctrl.layer[IW-1:0];
            end
            else if (in_range)
            begin
                entry_next = ctrl.from_left ? left : right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/layer_zorder_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_zorder_stack
// Pool of display layers with their stacking order: allocate, set height,
// free. The order list is a row of position cells that shift together.
// ----------------------------------------------------------------------------
//   port  dir  word
//   cmd   in   opcode, layer_id, requested_height
//   rsp   out  result_layer, status, applied_height, top_height
//
// A command runs from accept to response through lookup, one shift of
// the position cells, a sweep over every position that renumbers heights
// and finds the lowest free layer, then the response load. cmd.ready
// returns in the same cycle that rsp.valid rises.
// cmd.ready is high only between commands. The response register holds a
// word until taken; a finished command waits for it to drain.
// Reset is immediate; the order list needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module layer_zorder_stack
    import lzs_pkg::*;
#(
    parameter int MAX_LAYERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    lzs_in_if.sink    cmd,
    lzs_out_if.source rsp
);

    localparam int IW = $clog2(MAX_LAYERS);
    localparam int HW = IW + 1;
    localparam logic [IW-1:0]        LAST   = IW'(MAX_LAYERS - 1);
    localparam logic signed [HW-1:0] H_NONE = '1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg,   state_next;
    logic signed [HW-1:0]   top_reg,     top_next;
    logic [IW-1:0]          sweep_reg,   sweep_next;
    logic                   found_reg,   found_next;
    logic [IW-1:0]          free_reg,    free_next;
    logic                   out_vld_reg, out_vld_next;

    logic [1:0]             opcode_reg;
    logic [3:0]             id_reg;
    logic signed [4:0]      req_reg;
    logic                   pool_reg;
    logic signed [HW-1:0]   old_reg;
    logic signed [HW-1:0]   new_reg;

    logic [3:0]             out_layer_reg;
    logic                   out_status_reg;
    logic signed [4:0]      out_applied_reg;
    logic signed [4:0]      out_top_reg;

    logic signed [HW-1:0]   height_reg [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]  used_reg;

    logic [IW-1:0]          entry_w [MAX_LAYERS];
    shift_ctrl_t            ctrl;

    logic                   accept;
    logic                   done_go;
    logic [IW-1:0]          id_idx;
    logic signed [HW-1:0]   old_h;
    logic signed [POS_W-1:0] topx;
    logic signed [POS_W-1:0] limit;
    logic signed [POS_W-1:0] clamp;
    logic signed [HW-1:0]   tgt;
    logic signed [HW-1:0]   sweep_h;
    logic [IW-1:0]          sweep_entry;

    logic                   hw_en;
    logic [IW-1:0]          hw_addr;
    logic signed [HW-1:0]   hw_data;
    logic                   uw_en;
    logic [IW-1:0]          uw_addr;
    logic                   uw_data;

    assign accept      = cmd.valid && cmd.ready;
    assign cmd.ready   = (state_reg == S_IDLE);
    assign done_go     = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);
    assign id_idx      = IW'(id_reg);
    assign old_h       = height_reg[id_idx];
    assign topx        = POS_W'(top_reg);
    assign sweep_h     = $signed({1'b0, sweep_reg});
    assign sweep_entry = entry_w[sweep_reg];

    // clamp to -1..top+1, or -1..top for a shown layer
    always_comb
    begin
        limit = (old_h >= 0) ? topx : topx + P_ONE;
        clamp = POS_W'(req_reg);
        if (clamp > limit)
        begin
            clamp = limit;
        end
        if (clamp < P_NEG1)
        begin
            clamp = P_NEG1;
        end
        tgt = old_h;
        if (pool_reg && (opcode_reg == OP_SET) && used_reg[id_idx])
        begin
            tgt = HW'(clamp);
        end
        else if (pool_reg && (opcode_reg == OP_FREE) && (old_h >= 0))
        begin
            tgt = H_NONE;
        end
    end

    // shift window for the position cells
    always_comb
    begin
        ctrl       = '0;
        ctrl.pos   = POS_W'(new_reg);
        ctrl.layer = LYR_W'(id_idx);
        if ((state_reg == S_SHIFT) && (old_reg != new_reg))
        begin
            ctrl.en = 1'b1;
            if (old_reg > new_reg)
            begin
                if (new_reg >= 0)
                begin
                    ctrl.lo        = POS_W'(new_reg) + P_ONE;
                    ctrl.hi        = POS_W'(old_reg);
                    ctrl.from_left = 1'b1;
                    ctrl.ins       = 1'b1;
                end
                else
                begin
                    ctrl.lo        = POS_W'(old_reg);
                    ctrl.hi        = topx - P_ONE;
                    ctrl.from_left = 1'b0;
                    ctrl.ins       = 1'b0;
                end
            end
            else
            begin
                if (old_reg >= 0)
                begin
                    ctrl.lo        = POS_W'(old_reg);
                    ctrl.hi        = POS_W'(new_reg) - P_ONE;
                    ctrl.from_left = 1'b0;
                    ctrl.ins       = 1'b1;
                end
                else
                begin
                    ctrl.lo        = POS_W'(new_reg) + P_ONE;
                    ctrl.hi        = topx + P_ONE;
                    ctrl.from_left = 1'b1;
                    ctrl.ins       = 1'b1;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LAYERS; g++)
        begin : g_cell
            logic [IW-1:0] left_w;
            logic [IW-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = entry_w[g];
            end
            else
            begin : g_left
                assign left_w = entry_w[g-1];
            end

            if (g == MAX_LAYERS - 1)
            begin : g_last
                assign right_w = entry_w[g];
            end
            else
            begin : g_right
                assign right_w = entry_w[g+1];
            end

            lzs_cell #(
                .IW  (IW),
                .POS (g)
            ) u_cell (
                .clk   (clk),
                .left  (left_w),
                .right (right_w),
                .ctrl  (ctrl),
                .entry (entry_w[g])
            );
        end
    endgenerate

    // single write port into the per-layer tables
    always_comb
    begin
        hw_en   = 1'b0;
        hw_addr = id_idx;
        hw_data = new_reg;
        uw_en   = 1'b0;
        uw_addr = id_idx;
        uw_data = 1'b0;
        case (state_reg)
            S_SHIFT:
            begin
                hw_en = (old_reg != new_reg);
                uw_en = pool_reg && (opcode_reg == OP_FREE);
            end
            S_SWEEP:
            begin
                hw_en   = (sweep_h <= top_reg);
                hw_addr = sweep_entry;
                hw_data = sweep_h;
            end
            S_DONE:
            begin
                if (done_go && (opcode_reg == OP_ALLOC) && found_reg)
                begin
                    hw_en   = 1'b1;
                    hw_addr = free_reg;
                    hw_data = H_NONE;
                    uw_en   = 1'b1;
                    uw_addr = free_reg;
                    uw_data = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        sweep_next   = sweep_reg;
        found_next   = found_reg;
        free_next    = free_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                    found_next = 1'b0;
                end
            end
            S_LOOK:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                sweep_next = '0;
                state_next = S_SWEEP;
                if ((old_reg >= 0) && (new_reg < 0))
                begin
                    top_next = top_reg - HW'(1);
                end
                else if ((old_reg < 0) && (new_reg >= 0))
                begin
                    top_next = top_reg + HW'(1);
                end
            end
            S_SWEEP:
            begin
                if (!found_reg && !used_reg[sweep_reg])
                begin
                    found_next = 1'b1;
                    free_next  = sweep_reg;
                end
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            top_reg     <= H_NONE;
            sweep_reg   <= '0;
            found_reg   <= 1'b0;
            free_reg    <= '0;
            out_vld_reg <= 1'b0;
            used_reg    <= '0;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                height_reg[i] <= H_NONE;
            end
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            sweep_reg   <= sweep_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            out_vld_reg <= out_vld_next;
            if (hw_en)
            begin
                height_reg[hw_addr] <= hw_data;
            end
            if (uw_en)
            begin
                used_reg[uw_addr] <= uw_data;
            end
        end
    end

    // command and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= cmd.opcode;
            id_reg     <= cmd.layer_id;
            req_reg    <= cmd.requested_height;
            pool_reg   <= (int'(cmd.layer_id) < MAX_LAYERS);
        end
        if (state_reg == S_LOOK)
        begin
            old_reg <= old_h;
            new_reg <= tgt;
        end
        if (done_go)
        begin
            out_top_reg <= 5'(top_reg);
            if (opcode_reg == OP_ALLOC)
            begin
                out_layer_reg   <= found_reg ? 4'(free_reg) : 4'd0;
                out_status_reg  <= found_reg ? STATUS_OK : STATUS_FULL;
                out_applied_reg <= 5'(H_NONE);
            end
            else
            begin
                out_layer_reg   <= id_reg;
                out_status_reg  <= STATUS_OK;
                out_applied_reg <= pool_reg ? 5'(old_h) : 5'(H_NONE);
            end
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.result_layer   = out_layer_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.applied_height = out_applied_reg;
    assign rsp.top_height     = out_top_reg;

    `ASSERT_IMP(a_top_range, clk, rst_n, 1'b1,
        (top_reg >= H_NONE) && (top_reg <= $signed({1'b0, LAST})), "top out of range")
    `ASSERT_NXT(a_top_only_shift, clk, rst_n, state_reg != S_SHIFT, $stable(top_reg),
        "top moved outside shift")
    `ASSERT_IMP(a_rsp_from_done, clk, rst_n, $rose(out_vld_reg), $past(state_reg == S_DONE),
        "response without finished command")
    `ASSERT_NXT(a_one_cmd, clk, rst_n, accept, !cmd.ready, "second command taken while busy")
    `ASSERT_IMP(a_free_released, clk, rst_n,
        (state_reg == S_DONE) && (opcode_reg == OP_FREE) && pool_reg,
        !used_reg[id_idx] && (old_h == H_NONE), "freed layer still held")

endmodule
